// ----- hw/rtl/mwc_pkg.sv -----
// Package for the multiply-with-carry random-number unit.
// Holds request codes, seed and multiplier constants, and the controller-to-datapath command type.
// No dependencies; every other RTL file imports it.
`default_nettype none

package mwc_pkg;

    // Fixed seeds restored by a default seeding request.
    localparam logic [31:0] SEED_LOW_DEFAULT  = 32'd521288629;
    localparam logic [31:0] SEED_HIGH_DEFAULT = 32'd62436069;

    // Multiply-with-carry multipliers for the high and low halves.
    localparam logic [31:0] MUL_HIGH = 32'd36969;
    localparam logic [31:0] MUL_LOW  = 32'd18000;

    // Number of discarded steps after every seeding request (0 to 2047).
    localparam int WARMUP_ROUNDS = 16;
    localparam int COUNT_W       = 11;
    localparam logic [COUNT_W-1:0] WARMUP_COUNT = COUNT_W'(WARMUP_ROUNDS);

    localparam int FUNC_W = 3;

    typedef enum logic [FUNC_W-1:0] {
        REQ_SEED_DEFAULT = 3'd0,
        REQ_SEED_SIMPLE  = 3'd1,
        REQ_SEED_MANUAL  = 3'd2,
        REQ_GET_RANDOM   = 3'd3
    } req_func_t;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    // Commands from the controller to the datapath, valid for one cycle each.
    typedef struct packed {
        logic load_default; // restore both halves to the fixed seeds
        logic load_low;     // load the low half from seed_a when it is nonzero
        logic load_high;    // load the high half from seed_b when it is nonzero
        logic step;         // advance both halves once
        logic capture;      // load the result value register
        logic capture_get;  // result value is the generator output, else zero
    } mwc_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mwc_req_if.sv -----
// Request and response channel interfaces for the random-number unit.
// Each carries valid, ready and its payload; depends on mwc_pkg for widths.
`default_nettype none

interface mwc_req_if
    import mwc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [31:0]       seed_a;
    logic [31:0]       seed_b;

    modport source (output valid, output func, output seed_a, output seed_b, input ready);
    modport sink   (input valid, input func, input seed_a, input seed_b, output ready);
endinterface

interface mwc_rsp_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [31:0] random_value;

    modport source (output valid, output status, output random_value, input ready);
    modport sink   (input valid, input status, input random_value, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/mwc_datapath.sv -----
// Datapath of the random-number unit: the two generator halves and the result value register.
// Acts on mwc_cmd_t commands from mwc_controller; depends on mwc_pkg.
`default_nettype none

module mwc_datapath
    import mwc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire mwc_cmd_t    cmd,
    input  wire logic [31:0] seed_a,
    input  wire logic [31:0] seed_b,
    output logic      [31:0] random_value
);

    logic [31:0] high_reg, high_next;
    logic [31:0] low_reg, low_next;
    logic [31:0] value_reg, value_next;
    logic [31:0] high_step;
    logic [31:0] low_step;

    // One multiply-with-carry step for each half, modulo 2^32.
    assign high_step = MUL_HIGH * {16'd0, high_reg[15:0]} + {16'd0, high_reg[31:16]};
    assign low_step  = MUL_LOW * {16'd0, low_reg[15:0]} + {16'd0, low_reg[31:16]};

    always_comb
    begin
        high_next  = high_reg;
        low_next   = low_reg;
        value_next = value_reg;
        if (cmd.load_default)
        begin
            high_next = SEED_HIGH_DEFAULT;
            low_next  = SEED_LOW_DEFAULT;
        end
        if (cmd.load_low && (seed_a != 32'd0))
        begin
            low_next = seed_a;
        end
        if (cmd.load_high && (seed_b != 32'd0))
        begin
            high_next = seed_b;
        end
        if (cmd.step)
        begin
            high_next = high_step;
            low_next  = low_step;
        end
        // The output is formed from the halves already stepped in an earlier cycle.
        if (cmd.capture)
        begin
            value_next = cmd.capture_get ? ({high_reg[15:0], 16'd0} + low_reg) : 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_reg <= SEED_HIGH_DEFAULT;
            low_reg  <= SEED_LOW_DEFAULT;
        end
        else
        begin
            high_reg <= high_next;
            low_reg  <= low_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign random_value = value_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/mwc_controller.sv -----
// Controller of the random-number unit: request sequencing, warm-up counting, response valid.
// Drives mwc_datapath through mwc_cmd_t; depends on mwc_pkg.
`default_nettype none

module mwc_controller
    import mwc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire logic [FUNC_W-1:0] func,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output logic                   status,
    output mwc_cmd_t               cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WARM,
        ST_GET,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               get_reg, get_next;
    logic               status_reg, status_next;
    logic               rsp_status_reg, rsp_status_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic               accept;
    logic               out_free;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        get_next        = get_reg;
        status_next     = status_reg;
        rsp_status_next = rsp_status_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        cmd             = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    get_next    = 1'b0;
                    status_next = STATUS_OK;
                    count_next  = WARMUP_COUNT;
                    case (func)
                        REQ_SEED_DEFAULT, REQ_SEED_SIMPLE, REQ_SEED_MANUAL:
                        begin
                            cmd.load_default = (func == REQ_SEED_DEFAULT);
                            cmd.load_low     = (func == REQ_SEED_SIMPLE)
                                             || (func == REQ_SEED_MANUAL);
                            cmd.load_high    = (func == REQ_SEED_MANUAL);
                            state_next       = (WARMUP_COUNT == '0) ? ST_DONE : ST_WARM;
                        end
                        REQ_GET_RANDOM:
                        begin
                            get_next   = 1'b1;
                            state_next = ST_GET;
                        end
                        default:
                        begin
                            status_next = STATUS_INVALID;
                            state_next  = ST_DONE;
                        end
                    endcase
                end
            end
            ST_WARM:
            begin
                cmd.step   = 1'b1;
                count_next = count_reg - COUNT_W'(1);
                if (count_reg == COUNT_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_GET:
            begin
                cmd.step   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    // The status moves into the response register together with the value.
                    cmd.capture     = 1'b1;
                    cmd.capture_get = get_reg;
                    rsp_status_next = status_reg;
                    rsp_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            get_reg        <= 1'b0;
            status_reg     <= STATUS_OK;
            rsp_status_reg <= STATUS_OK;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            get_reg        <= get_next;
            status_reg     <= status_next;
            rsp_status_reg <= rsp_status_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = rsp_status_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/mwc_random_generator_unit.sv -----
// Top level of the multiply-with-carry random-number unit.
// Joins mwc_controller and mwc_datapath to the request and response channels (mwc_req_if.sv).
//
// Channel | Dir | Payload                          | Handshake
// --------+-----+----------------------------------+--------------------------
// req     | in  | func[2:0], seed_a[31:0], seed_b  | valid & ready at clk edge
// rsp     | out | status, random_value[31:0]       | valid & ready at clk edge
//
// A get request passes from the accepting state through one generator step to a final
// state that forms and registers the output value, after which its response is valid.
// A seeding request passes from the accepting state through WARMUP_ROUNDS warm-up rounds,
// run by the single shared step unit at one warm-up round per cycle, to the final state;
// an invalid request goes from the accepting state straight to the final state.
// Reset is asynchronous and active low; it restores the fixed seeds and empties the
// response register. While the response register is still full and not taken, a
// finished request waits, but the next request is accepted as soon as the previous
// one has moved its result into the response register.
`default_nettype none

module mwc_random_generator_unit
    import mwc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    mwc_req_if.sink   req,
    mwc_rsp_if.source rsp
);

    // Command bundle from the sequencer to the generator datapath.
    mwc_cmd_t cmd;

    // The controller owns the handshakes, the warm-up counter and the status bit.
    mwc_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .func      (req.func),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .status    (rsp.status),
        .cmd       (cmd)
    );

    // The datapath owns both generator halves and the returned value. Seeds are
    // sampled in the acceptance cycle, when the controller issues the load commands.
    mwc_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .seed_a       (req.seed_a),
        .seed_b       (req.seed_b),
        .random_value (rsp.random_value)
    );

endmodule

`default_nettype wire

// ----- tb/sv/mwc_scoreboard_pkg.sv -----
// Scoreboard for the multiply-with-carry random-number unit testbench.
// Holds its own generator state and a queue of expected responses.
// Depends on mwc_pkg for request codes, seeds, multipliers and widths.
package mwc_scoreboard_pkg;

    import mwc_pkg::*;

    typedef struct packed {
        logic        status;
        logic [31:0] random_value;
    } mwc_result_t;

    class mwc_scoreboard;

        logic [31:0] high_half;
        logic [31:0] low_half;
        mwc_result_t expected_results[$];
        int          error_count;

        function new();
            high_half   = SEED_HIGH_DEFAULT;
            low_half    = SEED_LOW_DEFAULT;
            error_count = 0;
        endfunction

        // One multiply-with-carry step on both halves, 32-bit wraparound.
        function logic [31:0] advance_halves();
            high_half = MUL_HIGH * {16'd0, high_half[15:0]} + {16'd0, high_half[31:16]};
            low_half  = MUL_LOW * {16'd0, low_half[15:0]} + {16'd0, low_half[31:16]};
            return {high_half[15:0], 16'd0} + low_half;
        endfunction

        function void warm_up();
            repeat (WARMUP_ROUNDS) void'(advance_halves());
        endfunction

        // Called when the unit accepts a request item.
        function void note_request(logic [FUNC_W-1:0] func, logic [31:0] seed_a,
                                   logic [31:0] seed_b);
            mwc_result_t outcome;
            outcome.status       = STATUS_OK;
            outcome.random_value = '0;
            case (func)
                REQ_SEED_DEFAULT:
                begin
                    low_half  = SEED_LOW_DEFAULT;
                    high_half = SEED_HIGH_DEFAULT;
                    warm_up();
                end
                REQ_SEED_SIMPLE:
                begin
                    if (seed_a != '0)
                        low_half = seed_a;
                    warm_up();
                end
                REQ_SEED_MANUAL:
                begin
                    if (seed_a != '0)
                        low_half = seed_a;
                    if (seed_b != '0)
                        high_half = seed_b;
                    warm_up();
                end
                REQ_GET_RANDOM:
                begin
                    outcome.random_value = advance_halves();
                end
                default:
                begin
                    outcome.status = STATUS_INVALID;
                end
            endcase
            expected_results.push_back(outcome);
        endfunction

        task report(string what, logic [31:0] expected, logic [31:0] got);
            $display("[%0t] mismatch on %s: expected 0x%08h, got 0x%08h",
                     $realtime, what, expected, got);
            error_count++;
        endtask

        // Called when the unit hands over a response item.
        task check_result(logic status, logic [31:0] random_value);
            mwc_result_t oldest;
            if (expected_results.size() == 0)
            begin
                report("unexpected response", '0, {31'd0, status});
                return;
            end
            oldest = expected_results.pop_front();
            if (status !== oldest.status)
                report("status", {31'd0, oldest.status}, {31'd0, status});
            if (random_value !== oldest.random_value)
                report("random_value", oldest.random_value, random_value);
        endtask

        function int pending();
            return expected_results.size();
        endfunction

    endclass

endpackage

// ----- tb/sv/tb_mwc_random_generator_unit.sv -----
// Top-level testbench for mwc_random_generator_unit.
// Drives request items, takes response items with random back-pressure and checks them.
// Depends on mwc_pkg, the channel interfaces and mwc_scoreboard_pkg.
module tb_mwc_random_generator_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import mwc_pkg::*;
    import mwc_scoreboard_pkg::*;

    // The receiver holds off this long once enough responses have been taken, so
    // the unit fills its response register and has to stall its request side.
    localparam int PRESSURE_AFTER  = 150;
    localparam int PRESSURE_CYCLES = 500;

    // A seeding request is the slowest item; the drain wait after the last item
    // is a few of those long.
    localparam int DRAIN_CYCLES = 4 * (WARMUP_ROUNDS + 2);

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    logic clk;
    logic rst_n;

    mwc_req_if req_bus ();
    mwc_rsp_if rsp_bus ();

    mwc_random_generator_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    mwc_scoreboard sb = new();

    // When clear, neither side inserts random gaps, so back-to-back items are exercised.
    bit idle_on;
    int responses_taken;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the unit hangs or a handshake never completes.
    initial
    begin
        #10ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        if (!idle_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Seeds favor zero (which keeps the current half) and the all-ones extreme.
    function automatic logic [31:0] pick_seed();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 20)
            return '0;
        if (roll < 25)
            return ALL_ONES;
        return $urandom;
    endfunction

    // Offers one request item and returns at the edge where it is accepted.
    // Valid is only lowered when a gap precedes the item, so at most one
    // assignment to valid happens per time step.
    task automatic send_request(logic [FUNC_W-1:0] func, logic [31:0] seed_a,
                                logic [31:0] seed_b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid  <= 1'b1;
        req_bus.func   <= func;
        req_bus.seed_a <= seed_a;
        req_bus.seed_b <= seed_b;
        do
            @(posedge clk);
        while (!req_bus.ready);
        sb.note_request(func, seed_a, seed_b);
    endtask

    task automatic send_invalid();
        logic [FUNC_W-1:0] func;
        func = FUNC_W'($urandom_range(REQ_GET_RANDOM + 1, (1 << FUNC_W) - 1));
        send_request(func, $urandom, $urandom);
    endtask

    // Random traffic is mostly a seeding request followed by a run of gets, which
    // is how the generator is used; bare gets and invalid codes fill the rest.
    task automatic random_traffic(int count);
        int sent;
        int roll;
        int gets;
        sent = 0;
        while (sent < count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
            begin
                send_request(REQ_SEED_DEFAULT, $urandom, $urandom);
                sent++;
            end
            else if (roll < 35)
            begin
                send_request(REQ_SEED_SIMPLE, pick_seed(), pick_seed());
                sent++;
            end
            else if (roll < 70)
            begin
                send_request(REQ_SEED_MANUAL, pick_seed(), pick_seed());
                sent++;
            end
            else if (roll < 80)
            begin
                send_invalid();
                sent++;
            end
            // Every branch is followed by a run of gets, so the new state is read out.
            gets = $urandom_range(1, 8);
            repeat (gets)
            begin
                send_request(REQ_GET_RANDOM, $urandom, $urandom);
                sent++;
            end
        end
    endtask

    // Response side: checks every handshake and decides ready for the next edge.
    initial
    begin : response_sink
        int  stall_left;
        bit  pressure_done;
        stall_left      = 0;
        pressure_done   = 1'b0;
        responses_taken = 0;
        rsp_bus.ready   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                sb.check_result(rsp_bus.status, rsp_bus.random_value);
                responses_taken++;
            end
            if (!pressure_done && responses_taken >= PRESSURE_AFTER)
            begin
                // Long hold-off while the sender keeps offering items.
                stall_left    = PRESSURE_CYCLES;
                pressure_done = 1'b1;
            end
            else if (stall_left == 0)
            begin
                stall_left = pick_gap();
            end
            if (stall_left > 0)
            begin
                rsp_bus.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        rst_n          = 1'b0;
        idle_on        = 1'b1;
        req_bus.valid  = 1'b0;
        req_bus.func   = REQ_SEED_DEFAULT;
        req_bus.seed_a = '0;
        req_bus.seed_b = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. First the values straight from the reset seeds, then
        // every invalid code, which must leave the generator state untouched.
        send_request(REQ_GET_RANDOM, '0, '0);
        send_request(REQ_GET_RANDOM, ALL_ONES, ALL_ONES);
        for (int code = REQ_GET_RANDOM + 1; code < (1 << FUNC_W); code++)
            send_request(FUNC_W'(code), ALL_ONES, ALL_ONES);
        send_request(REQ_GET_RANDOM, '0, '0);

        // Simple seeding: a zero seed keeps the low half, and seed_b is ignored.
        send_request(REQ_SEED_SIMPLE, '0, ALL_ONES);
        send_request(REQ_GET_RANDOM, '0, '0);
        send_request(REQ_SEED_SIMPLE, ALL_ONES, '0);
        send_request(REQ_GET_RANDOM, '0, '0);

        // Manual seeding with every zero and nonzero combination of the seeds.
        send_request(REQ_SEED_MANUAL, '0, '0);
        send_request(REQ_GET_RANDOM, '0, '0);
        send_request(REQ_SEED_MANUAL, 32'd1, '0);
        send_request(REQ_GET_RANDOM, '0, '0);
        send_request(REQ_SEED_MANUAL, '0, ALL_ONES);
        send_request(REQ_GET_RANDOM, '0, '0);
        send_request(REQ_SEED_MANUAL, ALL_ONES, ALL_ONES);
        send_request(REQ_GET_RANDOM, '0, '0);
        send_request(REQ_GET_RANDOM, '0, '0);

        // Default seeding ignores both seeds and restores the fixed ones.
        send_request(REQ_SEED_DEFAULT, ALL_ONES, ALL_ONES);
        send_request(REQ_GET_RANDOM, '0, '0);

        // Back-to-back phase, during which the long receiver hold-off falls,
        // then the main random phase with gaps on both sides.
        idle_on = 1'b0;
        random_traffic(400);
        idle_on = 1'b1;
        random_traffic(1030);
        req_bus.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
